@@ rtl/core/woi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// woi_pkg
// Shared constants and the CORDIC arctangent table of the odometry integrator.
// ----------------------------------------------------------------------------
package woi_pkg;

  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned CW       = 34;  // CORDIC x/y/z width
  localparam int unsigned DIV_W    = 64;  // divider operand width

  localparam logic [31:0]        PHASE_K         = 32'd2239906698;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SEQ_ERR = 2'd1;
  localparam logic [1:0] ST_ZERO_DT = 2'd2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    v = 32'd0;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/woi_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// woi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module woi_cordic
  import woi_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          phase_i,
  output logic                 done_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic                 busy_q, flip_q, done_q;
  logic [4:0]           cnt_q;
  logic signed [CW-1:0] x_q, y_q, z_q, cos_q, sin_q;
  logic signed [CW-1:0] nx, ny, nz, at;
  logic [31:0]          ph_rot;
  logic                 flip_in;

  assign flip_in = phase_i[31] ^ phase_i[30];  // phase in [1/4, 3/4) turn
  assign ph_rot  = flip_in ? (phase_i + 32'h8000_0000) : phase_i;
  assign at      = signed'({2'b00, atan_turn(cnt_q)});

  always_comb begin
    if (!z_q[CW-1]) begin
      nx = x_q - (y_q >>> cnt_q);
      ny = y_q + (x_q >>> cnt_q);
      nz = z_q - at;
    end else begin
      nx = x_q + (y_q >>> cnt_q);
      ny = y_q - (x_q >>> cnt_q);
      nz = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip_in;
      x_q    <= CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= CW'(signed'(ph_rot));
    end else if (busy_q) begin
      x_q <= nx;
      y_q <= ny;
      z_q <= nz;
      if (cnt_q == 5'(STEPS - 1)) begin
        cos_q <= flip_q ? -nx : nx;
        sin_q <= flip_q ? -ny : ny;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

@@ rtl/core/woi_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// woi_divider
// Restoring divider, one quotient bit per cycle, signed 32-bit saturated out.
// ----------------------------------------------------------------------------
module woi_divider
  import woi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  num_i,   // magnitude, rounding offset included
  input  logic [DIV_W-1:0]  den_i,
  input  logic              neg_i,
  output logic              done_o,
  output logic signed [31:0] res_o
);

  logic               busy_q, done_q, neg_q;
  logic [5:0]         cnt_q;
  logic [DIV_W-1:0]   rem_q, quo_q, den_q, rem_n, quo_n;
  logic [DIV_W:0]     trial;
  logic signed [31:0] res_q, sat;

  assign trial = {rem_q, quo_q[DIV_W-1]};

  always_comb begin
    if (trial >= {1'b0, den_q}) begin
      rem_n = DIV_W'(trial - {1'b0, den_q});
      quo_n = {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_n = trial[DIV_W-1:0];
      quo_n = {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (!neg_q) begin
      sat = (|quo_n[DIV_W-1:31]) ? 32'sh7FFF_FFFF : signed'(quo_n[31:0]);
    end else if ((|quo_n[DIV_W-1:32]) || (quo_n[31] && (|quo_n[30:0]))) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = signed'(-quo_n[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (cnt_q == 6'(DIV_W - 1)) res_q <= sat;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/wheel_odometry_integrator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_odometry_integrator_unit
// Dead-reckoning pose integrator with midpoint-heading rotation.
// ----------------------------------------------------------------------------
// Takes one odometry request at a time (byte-swapped dx/dy/dtheta words, a
// sequence byte, a timestamp) and returns one result: status, wrapped pose,
// saturated body velocities and yaw rate, and the heading quaternion. A
// request whose sequence byte is not the previous one plus one is dropped
// (status 1) after resyncing; the very first request is always taken.
// in_ready_o is high only while the sequencer idles. An accepted request with
// nonzero elapsed time goes from acceptance to out_valid_o through two CORDIC
// passes, the rotation products (S_RX0 to S_RYF), three passes of the
// bit-serial divider (64 quotient bits each, plus operand setup and handoff)
// and the packing of the result. A dropped request makes one CORDIC pass; one
// with zero elapsed time makes two and the rotation products but no divider
// pass. in_ready_o rises the cycle after the result is loaded; a result still
// waiting in the output register holds the sequencer in its last state until
// the receiver takes it. A finished result sits in the output register while
// the next request is accepted.
// ----------------------------------------------------------------------------
module wheel_odometry_integrator_unit
  import woi_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int CORDIC_STEPS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        dx_raw_i,
  input  logic [15:0]        dy_raw_i,
  input  logic [15:0]        dth_raw_i,
  input  logic [7:0]         seq_num_i,
  input  logic [31:0]        stamp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] yaw_rate_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MPH, S_CSTART, S_CWAIT, S_RX0, S_RX1, S_RY0, S_RY1, S_RYF,
    S_VMUL, S_DSTART, S_DWAIT, S_QOUT, S_DONE
  } state_e;

  typedef enum logic [1:0] { J_VX, J_VY, J_WZ } job_e;

  state_e state_q;
  job_e   job_q;

  // sequence / pose state
  logic        first_q;
  logic [7:0]  prev_seq_q;
  logic [31:0] acc_x_q, acc_y_q, acc_h_q, last_t_q;

  // per-request working registers
  logic signed [15:0] dx_q, dy_q, dth_q;
  logic [31:0]        dt_q;
  logic [1:0]         stat_q;
  logic               quat_q;
  logic signed [33:0] angle_q;
  logic signed [71:0] prod_q, sum_q;
  logic signed [35:0] rx_q, ry_q;
  logic signed [31:0] vx_q, vy_q, wz_q;
  logic signed [15:0] qz_q, qw_q;

  // output register
  logic               ovalid_q;
  logic [1:0]         o_stat_q;
  logic signed [31:0] o_px_q, o_py_q, o_h_q, o_vx_q, o_vy_q, o_wz_q;
  logic signed [15:0] o_qz_q, o_qw_q;

  logic signed [15:0] dx_sw, dy_sw, dth_sw;
  logic               seq_ok, in_fire;
  logic [31:0]        dt_in;

  assign dx_sw  = signed'({dx_raw_i[7:0], dx_raw_i[15:8]});
  assign dy_sw  = signed'({dy_raw_i[7:0], dy_raw_i[15:8]});
  assign dth_sw = signed'({dth_raw_i[7:0], dth_raw_i[15:8]});
  assign seq_ok = first_q || ((seq_num_i - prev_seq_q) == 8'd1);
  assign dt_in  = stamp_i - last_t_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // shared multiplier, operands picked by the sequencer
  logic signed [35:0] ma, mb;
  logic signed [71:0] prod_d;
  logic signed [33:0] c_w, s_w;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_MPH: begin
        ma = 36'(angle_q);
        mb = signed'({4'b0000, PHASE_K});
      end
      S_RX0: begin ma = 36'(dx_q);  mb = 36'(c_w); end
      S_RX1: begin ma = 36'(dy_q);  mb = 36'(s_w); end
      S_RY0: begin ma = -36'(dx_q); mb = 36'(s_w); end
      S_RY1: begin ma = 36'(dy_q);  mb = 36'(c_w); end
      S_VMUL: begin
        unique case (job_q)
          J_VX:    ma = rx_q;
          J_VY:    ma = ry_q;
          default: ma = 36'(dth_q);
        endcase
        mb = signed'(36'(TICKS_PER_SECOND));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = ma * mb;

  // Q30 to Q16 with round-half-up
  logic signed [71:0] rsum;
  logic signed [71:0] rshift;
  assign rsum   = sum_q + prod_q + 72'sd8192;
  assign rshift = rsum >>> 14;

  // CORDIC
  logic c_start, c_done;
  assign c_start = (state_q == S_CSTART);

  woi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .phase_i (prod_q[47:16]),
    .done_o  (c_done),
    .cos_o   (c_w),
    .sin_o   (s_w)
  );

  // divider operands: magnitude plus half the divisor
  logic               d_start, d_done, d_neg;
  logic [71:0]        pabs;
  logic [63:0]        d_num, d_den, d_half;
  logic signed [31:0] d_res;

  assign d_start = (state_q == S_DSTART);
  assign d_neg   = prod_q[71];
  assign pabs    = d_neg ? 72'(-prod_q) : 72'(prod_q);
  assign d_den   = (job_q == J_WZ) ? {32'd0, dt_q} : {16'd0, dt_q, 16'd0};
  assign d_half  = (job_q == J_WZ) ? {33'd0, dt_q[31:1]} : {17'd0, dt_q, 15'd0};
  assign d_num   = pabs[63:0] + d_half;

  woi_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d_start),
    .num_i   (d_num),
    .den_i   (d_den),
    .neg_i   (d_neg),
    .done_o  (d_done),
    .res_o   (d_res)
  );

  // Q4.30 to Q1.15, rounded and clamped
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767)       return 16'sh7FFF;
    else if (r < -34'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

  logic load_out;
  assign load_out = (state_q == S_DONE) && (!ovalid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      job_q      <= J_VX;
      first_q    <= 1'b1;
      prev_seq_q <= 8'd255;
      acc_x_q    <= '0;
      acc_y_q    <= '0;
      acc_h_q    <= '0;
      last_t_q   <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i && !load_out) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            first_q    <= 1'b0;
            prev_seq_q <= seq_num_i;
            if (seq_ok) begin
              acc_x_q  <= acc_x_q + 32'(dx_sw);
              acc_y_q  <= acc_y_q + 32'(dy_sw);
              acc_h_q  <= acc_h_q + 32'(dth_sw);
              last_t_q <= stamp_i;
            end
            state_q <= S_MPH;
          end
        end
        S_MPH:    state_q <= S_CSTART;
        S_CSTART: state_q <= S_CWAIT;
        S_CWAIT:  if (c_done) state_q <= quat_q ? S_QOUT : S_RX0;
        S_RX0:    state_q <= S_RX1;
        S_RX1:    state_q <= S_RY0;
        S_RY0:    state_q <= S_RY1;
        S_RY1:    state_q <= S_RYF;
        S_RYF: begin
          job_q   <= J_VX;
          state_q <= (dt_q == 32'd0) ? S_MPH : S_VMUL;
        end
        S_VMUL:   state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (d_done) begin
            unique case (job_q)
              J_VX: begin job_q <= J_VY; state_q <= S_VMUL; end
              J_VY: begin job_q <= J_WZ; state_q <= S_VMUL; end
              default: state_q <= S_MPH;
            endcase
          end
        end
        S_QOUT: state_q <= S_DONE;
        S_DONE: begin
          if (load_out) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          dx_q  <= dx_sw;
          dy_q  <= dy_sw;
          dth_q <= dth_sw;
          dt_q  <= dt_in;
          vx_q  <= '0;
          vy_q  <= '0;
          wz_q  <= '0;
          if (seq_ok) begin
            // midpoint angle in half units: 2*heading + dth
            angle_q <= {acc_h_q[31], acc_h_q, 1'b0} + 34'(dth_sw);
            quat_q  <= 1'b0;
            stat_q  <= (dt_in == 32'd0) ? ST_ZERO_DT : ST_OK;
          end else begin
            angle_q <= 34'(signed'(acc_h_q));
            quat_q  <= 1'b1;
            stat_q  <= ST_SEQ_ERR;
          end
        end
      end
      S_RX1: sum_q <= prod_q;
      S_RY0: rx_q  <= rshift[35:0];
      S_RY1: sum_q <= prod_q;
      S_RYF: begin
        ry_q <= rshift[35:0];
        if (dt_q == 32'd0) begin
          angle_q <= 34'(signed'(acc_h_q));
          quat_q  <= 1'b1;
        end
      end
      S_DWAIT: begin
        if (d_done) begin
          unique case (job_q)
            J_VX: vx_q <= d_res;
            J_VY: vy_q <= d_res;
            default: begin
              wz_q    <= d_res;
              angle_q <= 34'(signed'(acc_h_q));
              quat_q  <= 1'b1;
            end
          endcase
        end
      end
      S_QOUT: begin
        qz_q <= to_q15(s_w);
        qw_q <= to_q15(c_w);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      o_stat_q <= stat_q;
      o_px_q   <= signed'(acc_x_q);
      o_py_q   <= signed'(acc_y_q);
      o_h_q    <= signed'(acc_h_q);
      o_vx_q   <= vx_q;
      o_vy_q   <= vy_q;
      o_wz_q   <= wz_q;
      o_qz_q   <= qz_q;
      o_qw_q   <= qw_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = o_stat_q;
  assign pos_x_o     = o_px_q;
  assign pos_y_o     = o_py_q;
  assign heading_o   = o_h_q;
  assign vel_x_o     = o_vx_q;
  assign vel_y_o     = o_vy_q;
  assign yaw_rate_o  = o_wz_q;
  assign quat_z_o    = o_qz_q;
  assign quat_w_o    = o_qw_q;

endmodule

@@ test/wheel_odometry_integrator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_odometry_integrator_unit_test
// Self-checking bench for the odometry integrator.
// ----------------------------------------------------------------------------
// Drives odometry requests (directed corners, then mostly in-sequence random
// runs with a share of sequence breaks and repeated stamps), predicts the
// pose, velocity and quaternion of every request in its own model and checks
// each result against the oldest prediction. Both sides idle at random, and
// the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------

class odo_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pos_x, pos_y, heading, vel_x, vel_y, yaw_rate;
    logic [15:0] quat_z, quat_w;
  } odo_result_t;

  int tps;
  int steps;
  bit first_seen;
  logic [7:0] prev_seq;
  logic [31:0] acc_x, acc_y, acc_hd, last_time;
  odo_result_t pending[$];
  int errors;
  int n_seq_err, n_zero_dt, n_ok;

  function new(int tps_i, int steps_i);
    tps = tps_i;
    steps = steps_i;
    first_seen = 1;
    prev_seq = 8'hFF;
    acc_x = 0; acc_y = 0; acc_hd = 0; last_time = 0;
    errors = 0;
  endfunction

  static function longint unswap(logic [15:0] w);
    logic [15:0] s;
    s = {w[7:0], w[15:8]};
    return longint'($signed(s));
  endfunction

  static function longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  static function logic [31:0] phase_of(longint m);
    logic [63:0] p;
    p = 64'(m) * 64'd2239906698;
    return p[47:16];
  endfunction

  static function longint atan_step(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function void rotate(logic [31:0] ph, output longint c, output longint s);
    logic [31:0] q;
    bit flip;
    longint x, y, z, nx, ny;
    q = ph + 32'h4000_0000;
    flip = q[31];
    if (flip) ph = ph + 32'h8000_0000;
    x = 652032874; y = 0;
    z = longint'($signed(ph));
    for (int i = 0; i < steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_step(i);
      end else begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_step(i);
      end
      x = nx; y = ny;
    end
    if (flip) begin x = -x; y = -y; end
    c = x; s = y;
  endfunction

  static function longint rdiv(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag, q;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    if (q > 64'd4294967296) q = 64'd4294967296;
    if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  static function logic [15:0] to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Note one accepted request and queue its expected result.
  function void note_request(logic [15:0] dxr, logic [15:0] dyr, logic [15:0] dthr,
                             logic [7:0] seq, logic [31:0] stamp);
    longint dx, dy, dth, c, s, rx, ry, qc, qs, vx, vy, wz;
    logic [31:0] dt;
    logic [7:0] diff;
    bit take;
    odo_result_t r;
    dx = unswap(dxr); dy = unswap(dyr); dth = unswap(dthr);
    vx = 0; vy = 0; wz = 0;
    diff = seq - prev_seq;
    take = first_seen || diff == 8'd1;
    first_seen = 0;
    prev_seq = seq;
    r.status = woi_pkg::ST_OK;
    if (!take) begin
      r.status = woi_pkg::ST_SEQ_ERR;
      n_seq_err++;
    end else begin
      rotate(phase_of(2 * longint'($signed(acc_hd)) + dth), c, s);
      rx = (dx * c + dy * s + 8192) >>> 14;
      ry = (-dx * s + dy * c + 8192) >>> 14;
      dt = stamp - last_time;
      acc_x += 32'(dx); acc_y += 32'(dy); acc_hd += 32'(dth);
      last_time = stamp;
      if (dt == 0) begin
        r.status = woi_pkg::ST_ZERO_DT;
        n_zero_dt++;
      end else begin
        vx = rdiv(rx * tps, {16'd0, dt, 16'd0});
        vy = rdiv(ry * tps, {16'd0, dt, 16'd0});
        wz = rdiv(dth * tps, {32'd0, dt});
        n_ok++;
      end
    end
    rotate(phase_of(longint'($signed(acc_hd))), qc, qs);
    r.pos_x = acc_x; r.pos_y = acc_y; r.heading = acc_hd;
    r.vel_x = vx[31:0]; r.vel_y = vy[31:0]; r.yaw_rate = wz[31:0];
    r.quat_z = to_q15(qs); r.quat_w = to_q15(qc);
    pending.push_back(r);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("ERROR %s: got %h expected %h", what, got, want);
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(odo_result_t got);
    odo_result_t w;
    if (pending.size() == 0) begin
      report("unexpected result", got.pos_x, 0);
      return;
    end
    w = pending.pop_front();
    if (got.status !== w.status) report("status", got.status, w.status);
    if (got.pos_x !== w.pos_x) report("pos_x", got.pos_x, w.pos_x);
    if (got.pos_y !== w.pos_y) report("pos_y", got.pos_y, w.pos_y);
    if (got.heading !== w.heading) report("heading", got.heading, w.heading);
    if (got.vel_x !== w.vel_x) report("vel_x", got.vel_x, w.vel_x);
    if (got.vel_y !== w.vel_y) report("vel_y", got.vel_y, w.vel_y);
    if (got.yaw_rate !== w.yaw_rate) report("yaw_rate", got.yaw_rate, w.yaw_rate);
    if (got.quat_z !== w.quat_z) report("quat_z", got.quat_z, w.quat_z);
    if (got.quat_w !== w.quat_w) report("quat_w", got.quat_w, w.quat_w);
  endfunction
endclass

module wheel_odometry_integrator_unit_test;
  import woi_pkg::*;

  localparam int TPS   = 1000000;
  localparam int STEPS = 16;
  localparam int N_RANDOM = 1080;
  // Allow for the slowest request, long idles on both sides, the long
  // hold-off, and a wide margin on top.
  localparam longint CYCLE_LIMIT = 1200 * (260 + 80 + 80) * 2 + 200000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [15:0] dx_raw_i = 0, dy_raw_i = 0, dth_raw_i = 0;
  logic [7:0] seq_num_i = 0;
  logic [31:0] stamp_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic signed [31:0] pos_x_o, pos_y_o, heading_o, vel_x_o, vel_y_o, yaw_rate_o;
  logic signed [15:0] quat_z_o, quat_w_o;

  wheel_odometry_integrator_unit #(.TICKS_PER_SECOND(TPS), .CORDIC_STEPS(STEPS)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .dx_raw_i, .dy_raw_i, .dth_raw_i,
    .seq_num_i, .stamp_i, .out_valid_o, .out_ready_i, .status_o, .pos_x_o,
    .pos_y_o, .heading_o, .vel_x_o, .vel_y_o, .yaw_rate_o, .quat_z_o, .quat_w_o
  );

  always #5 clk_i = ~clk_i;

  odo_scoreboard odo_model = new(TPS, STEPS);
  longint cycle_count = 0;
  bit hold_off = 0;       // receiver forced to stall
  bit hold_done = 0;
  int sent_count = 0;

  // Mostly short gaps, a few long ones, sometimes none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Byte-swap a signed value into the wire format.
  function automatic logic [15:0] wire_word(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // One request: raise valid, hold until accepted, then sometimes idle a while.
  task automatic send_request(logic [15:0] dxr, logic [15:0] dyr, logic [15:0] dthr,
                              logic [7:0] seq, logic [31:0] stamp);
    int g;
    in_valid_i <= 1;
    dx_raw_i <= dxr; dy_raw_i <= dyr; dth_raw_i <= dthr;
    seq_num_i <= seq; stamp_i <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    odo_model.note_request(dxr, dyr, dthr, seq, stamp);
    sent_count++;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Receiver: random idle after each result, plus one long hold-off.
  initial begin
    int g;
    g = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        odo_model.check_result('{status_o, pos_x_o, pos_y_o, heading_o, vel_x_o,
                                 vel_y_o, yaw_rate_o, quat_z_o, quat_w_o});
        g = gap_len();
      end
      if (hold_off) begin
        out_ready_i <= 0;
      end else if (g > 0) begin
        out_ready_i <= 0;
        g--;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // Long hold-off counted in its own process; the sender keeps offering.
  initial begin
    @(posedge rst_ni);
    wait (sent_count >= 60);
    @(posedge clk_i);
    hold_off = 1;
    repeat (3000) @(posedge clk_i);
    hold_off = 0;
    hold_done = 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("wheel_odometry_integrator_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] seq;
    logic [31:0] stamp;
    logic [15:0] dx, dy, dth;
    int mode, r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: first request at time zero (zero elapsed time), odd sequence.
    send_request(wire_word(16'h7FFF), wire_word(16'h8000), wire_word(16'h7FFF), 8'd42, 0);
    send_request(wire_word(16'h8000), wire_word(16'h7FFF), wire_word(16'h8000), 8'd43, 1);
    send_request(16'hFFFF, 16'h0000, 16'h0001, 8'd44, 32'hFFFF_FFFF);
    send_request(16'h0000, 16'hFFFF, 16'h0100, 8'd45, 32'hFFFF_FFFF); // repeated stamp
    send_request(16'h1234, 16'h5678, 16'h9ABC, 8'd47, 32'd100);       // sequence skip
    send_request(16'h1234, 16'h5678, 16'h9ABC, 8'd47, 32'd100);       // repeat seq
    send_request(16'h00FF, 16'hFF00, 16'h55AA, 8'd48, 32'd0);         // stamp wraps
    send_request(16'hAA55, 16'h0F0F, 16'hF0F0, 8'd255, 32'd5);
    send_request(wire_word(16'd1000), wire_word(-16'sd1000), wire_word(16'd31416),
                 8'd0, 32'd10000);                                    // 255 -> 0 wrap
    send_request(wire_word(16'd1000), wire_word(16'd1000), wire_word(16'd31416),
                 8'd1, 32'd20000);
    // Huge rate: tiny dt with full-scale increments saturates the velocities.
    send_request(wire_word(16'h7FFF), wire_word(16'h7FFF), wire_word(16'h7FFF),
                 8'd2, 32'd20001);
    send_request(wire_word(16'h8000), wire_word(16'h8000), wire_word(16'h8000),
                 8'd3, 32'd20002);
    seq = 8'd3;
    stamp = 32'd20002;

    // Random: in-sequence runs with big heading steps to reach the wrap,
    // plus breaks, repeated stamps and raw noise.
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 99);
      dx = 16'($urandom); dy = 16'($urandom); dth = 16'($urandom);
      if (mode < 30) begin
        dx = 16'($urandom_range(0, 400) - 200); dy = 16'($urandom_range(0, 400) - 200);
        dth = 16'($urandom_range(0, 2000) - 1000);
      end
      r = $urandom_range(0, 99);
      if (r < 80) seq = seq + 8'd1;
      else if (r < 90) seq = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) stamp = stamp;
      else if (r < 12) stamp = $urandom;
      else if (r < 20) stamp = stamp + $urandom_range(1, 3);
      else stamp = stamp + $urandom_range(1000, 200000);
      send_request(mode < 30 ? wire_word(dx) : dx, mode < 30 ? wire_word(dy) : dy,
                   mode < 30 ? wire_word(dth) : dth, seq, stamp);
    end
    in_valid_i <= 0;

    wait (hold_done && odo_model.pending.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("covered %0d requests: %0d with velocity, %0d zero elapsed, %0d dropped",
             sent_count, odo_model.n_ok, odo_model.n_zero_dt, odo_model.n_seq_err);
    if (odo_model.errors == 0 && odo_model.pending.size() == 0) begin
      $display("wheel_odometry_integrator_unit: match");
    end else begin
      $display("wheel_odometry_integrator_unit: mismatch");
    end
    $finish;
  end
endmodule
